[rtl/core/fnv1a_verdict_cache_assert.svh]
// Assertion helpers for the verdict cache. Both sample on clk and stay off during rst.
`ifndef FNV1A_VERDICT_CACHE_ASSERT_SVH
`define FNV1A_VERDICT_CACHE_ASSERT_SVH

// Same-cycle implication.
`define FVC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FVC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/fvc_pkg.sv]
`timescale 1ns / 1ps

package fvc_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int OCC_W         = 9;
  localparam int LEN_W         = 16;
  localparam int IN_DATA_W     = 80;
  localparam int OUT_DATA_W    = 120;
  localparam int ENTRY_W       = 8 + 32 + 64;

  // queue depth must be a power of two so the pointers wrap on their own
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [63:0]      FNV_BASIS        = 64'hcbf2_9ce4_8422_2325;
  localparam logic [LEN_W-1:0] MIN_LENGTH_RESET = 16'd24;
  localparam logic [LEN_W-1:0] LEN_MAX          = 16'hffff;

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_INVAL = 2'd1,
    CMD_FILL  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_SHORT      = 3'd0,
    ST_HIT        = 3'd1,
    ST_MISS       = 3'd2,
    ST_FILLED     = 3'd3,
    ST_INVAL      = 3'd4,
    ST_NO_MATCH   = 3'd5,
    ST_NO_PENDING = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    OP_SHORT  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_INVAL  = 2'd2,
    OP_FILL   = 2'd3
  } op_kind_t;

  typedef enum logic {
    B_IDLE = 1'b0,
    B_EXEC = 1'b1
  } back_state_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [63:0] hash;
    logic [7:0]  verdict;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [7:0]  verdict;
    logic [31:0] runs;
    logic [63:0] hash;
  } entry_t;

  // one FNV-1a round; the prime 2^40 + 0x1b3 becomes shift-adds
  function automatic logic [63:0] fnv_step(logic [63:0] h, logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

[rtl/core/fnv1a_verdict_cache.sv]
`timescale 1ns / 1ps
// FNV-1a 64 image hasher with a direct-mapped verdict cache.
// Slave stream: one word per image byte (tuser cmd 0, tlast on the final byte),
// an invalidate by hash (cmd 1) or a verifier fill for the pending miss (cmd 2).
// Master stream: one result word per image end, invalidate or fill; bytes that are
// not last give no result. min_length sits at APB address 0.
// Image bytes are taken one per cycle while tready is high; the hash round is
// combinational shift-adds. End-of-image, invalidate and fill words queue for
// the table side, which handles each with a registered table read, then update
// and result, and takes no new word before the last one is done; the result
// goes to the master side through the output register once that is free.
// Reset clears the valid bit of every entry at once, so the table reads as zero
// right away with no clearing pass; min_length returns to 24.
// When the receiver stalls the result register holds, the table side waits, the
// two-word queue fills and then tready drops on the slave side.
module fnv1a_verdict_cache (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [79:0]  s_tdata,   // data_byte[7:0], hash_in[71:8], verdict[79:72]
  input  logic [1:0]   s_tuser,   // cmd[1:0]
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata,   // verdict_out[7:0], run_count[39:8], occupied[48:40],
                                  // hash_out[112:49], zero pad above
  output logic [2:0]   m_tuser,   // status[2:0]
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  `include "fnv1a_verdict_cache_assert.svh"

  logic [fvc_pkg::LEN_W-1:0] min_length;
  logic                      q_push;
  logic                      q_pop;
  fvc_pkg::op_t              q_op;
  fvc_pkg::op_t              head_op;
  fvc_pkg::q_stat_t          q_stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, min_length} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= fvc_pkg::MIN_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      min_length <= pwdata[15:0];
    end
  end

  fvc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .min_length (min_length),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_op       (q_op)
  );

  fvc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (q_op),
    .pop     (q_pop),
    .head_op (head_op),
    .stat    (q_stat)
  );

  fvc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .head_op  (head_op),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  `FVC_ASSERT_IMPLY(a_push_room, q_push, !q_stat.full, "push into a full queue")
  `FVC_ASSERT_NEXT(a_pop_spacing, q_pop, !q_pop, "table side popped two words in a row")
  `FVC_ASSERT_IMPLY(a_occ_range, m_tvalid, m_tdata[48:40] <= 9'(fvc_pkg::TABLE_ENTRIES), "occupied count beyond table size")
  `FVC_ASSERT_IMPLY(a_fill_runs, m_tvalid && m_tuser == 3'(fvc_pkg::ST_FILLED), m_tdata[39:8] == 32'd1, "fill result without run count one")

endmodule

[rtl/core/fvc_ram.sv]
`timescale 1ns / 1ps

module fvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/fvc_front.sv]
`timescale 1ns / 1ps

module fvc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [fvc_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic [1:0]                    s_tuser,
  input  logic                          s_tlast,
  input  logic [fvc_pkg::LEN_W-1:0]     min_length,
  input  fvc_pkg::q_stat_t              q_stat,
  output logic                          q_push,
  output fvc_pkg::op_t                  q_op
);

  logic [63:0]               running_hash;
  logic [fvc_pkg::LEN_W-1:0] byte_count;
  logic [63:0]               hash_next;
  logic [fvc_pkg::LEN_W-1:0] count_next;
  logic                      accept;
  fvc_pkg::cmd_t             cmd;

  assign cmd        = fvc_pkg::cmd_t'(s_tuser);
  assign s_tready   = !q_stat.full;
  assign accept     = s_tvalid && s_tready;
  assign hash_next  = fvc_pkg::fnv_step(running_hash, s_tdata[7:0]);
  assign count_next = (byte_count == fvc_pkg::LEN_MAX) ? byte_count : byte_count + 16'd1;

  always_comb begin
    q_push       = 1'b0;
    q_op.kind    = fvc_pkg::OP_SHORT;
    q_op.hash    = hash_next;
    q_op.verdict = s_tdata[79:72];
    unique case (cmd)
      fvc_pkg::CMD_DATA: begin
        q_push    = accept && s_tlast;
        q_op.kind = (count_next < min_length) ? fvc_pkg::OP_SHORT : fvc_pkg::OP_LOOKUP;
      end
      fvc_pkg::CMD_INVAL: begin
        q_push    = accept;
        q_op.kind = fvc_pkg::OP_INVAL;
        q_op.hash = s_tdata[71:8];
      end
      fvc_pkg::CMD_FILL: begin
        q_push    = accept;
        q_op.kind = fvc_pkg::OP_FILL;
      end
      fvc_pkg::CMD_NONE: begin
        q_push = 1'b0;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= fvc_pkg::FNV_BASIS;
      byte_count   <= '0;
    end else if (accept && cmd == fvc_pkg::CMD_DATA) begin
      if (s_tlast) begin
        running_hash <= fvc_pkg::FNV_BASIS;
        byte_count   <= '0;
      end else begin
        running_hash <= hash_next;
        byte_count   <= count_next;
      end
    end
  end

endmodule

[rtl/core/fvc_queue.sv]
`timescale 1ns / 1ps

module fvc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  fvc_pkg::op_t     push_op,
  input  logic             pop,
  output fvc_pkg::op_t     head_op,
  output fvc_pkg::q_stat_t stat
);

  fvc_pkg::op_t               slots [fvc_pkg::QUEUE_DEPTH];
  logic [fvc_pkg::QPTR_W-1:0] wr_ptr;
  logic [fvc_pkg::QPTR_W-1:0] rd_ptr;
  logic [fvc_pkg::QCNT_W-1:0] count;

  assign head_op    = slots[rd_ptr];
  assign stat.full  = (count == fvc_pkg::QCNT_W'(fvc_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/fvc_back.sv]
`timescale 1ns / 1ps

module fvc_back (
  input  logic                           clk,
  input  logic                           rst,
  input  fvc_pkg::q_stat_t               q_stat,
  input  fvc_pkg::op_t                   head_op,
  output logic                           q_pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [fvc_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [2:0]                     m_tuser
);

  fvc_pkg::back_state_t        state;
  fvc_pkg::back_state_t        state_next;
  fvc_pkg::op_t                cur;
  logic [fvc_pkg::SLOT_W-1:0]  cur_slot;
  logic [fvc_pkg::SLOT_W-1:0]  rd_slot;
  logic                        cur_valid;
  logic [fvc_pkg::TABLE_ENTRIES-1:0] valid;
  logic [63:0]                 pending_hash;
  logic                        pending_valid;
  logic [fvc_pkg::OCC_W-1:0]   occupied_count;

  logic                        ram_re;
  logic                        ram_we;
  logic [fvc_pkg::ENTRY_W-1:0] ram_rdata;
  fvc_pkg::entry_t             wr_entry;
  fvc_pkg::entry_t             stored;

  logic                        exec_fire;
  logic                        out_free;
  logic                        set_valid;
  logic                        clr_valid;
  logic                        pend_set;
  logic                        pend_clr;
  logic [fvc_pkg::OCC_W-1:0]   occ_next;
  fvc_pkg::status_t            res_status;
  logic [7:0]                  res_verdict;
  logic [31:0]                 res_runs;
  logic [63:0]                 res_hash;

  logic                        out_valid;
  fvc_pkg::status_t            out_status;
  logic [7:0]                  out_verdict;
  logic [31:0]                 out_runs;
  logic [fvc_pkg::OCC_W-1:0]   out_occ;
  logic [63:0]                 out_hash;

  fvc_ram #(
    .WIDTH (fvc_pkg::ENTRY_W),
    .DEPTH (fvc_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_slot),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (rd_slot),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid || m_tready;
  // fill goes to the slot of the pending miss, which only the back side changes
  assign rd_slot  = (head_op.kind == fvc_pkg::OP_FILL) ? pending_hash[fvc_pkg::SLOT_W-1:0]
                                                       : head_op.hash[fvc_pkg::SLOT_W-1:0];
  // an entry never written since reset reads as all zero
  assign stored   = cur_valid ? fvc_pkg::entry_t'(ram_rdata) : '0;

  always_comb begin
    state_next = state;
    unique case (state)
      fvc_pkg::B_IDLE: begin
        if (!q_stat.empty) begin
          state_next = fvc_pkg::B_EXEC;
        end
      end
      fvc_pkg::B_EXEC: begin
        if (out_free) begin
          state_next = fvc_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = fvc_pkg::B_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    ram_re    = 1'b0;
    exec_fire = 1'b0;
    unique case (state)
      fvc_pkg::B_IDLE: begin
        q_pop  = !q_stat.empty;
        ram_re = !q_stat.empty;
      end
      fvc_pkg::B_EXEC: begin
        exec_fire = out_free;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_status  = fvc_pkg::ST_SHORT;
    res_verdict = '0;
    res_runs    = '0;
    res_hash    = cur.hash;
    ram_we      = 1'b0;
    wr_entry    = stored;
    set_valid   = 1'b0;
    clr_valid   = 1'b0;
    pend_set    = 1'b0;
    pend_clr    = 1'b0;
    occ_next    = occupied_count;
    unique case (cur.kind)
      fvc_pkg::OP_SHORT: begin
        res_status = fvc_pkg::ST_SHORT;
      end
      fvc_pkg::OP_LOOKUP: begin
        if (stored.hash == cur.hash) begin
          res_status    = fvc_pkg::ST_HIT;
          res_verdict   = stored.verdict;
          res_runs      = stored.runs + 32'd1;
          wr_entry.runs = res_runs;
          ram_we        = exec_fire;
          set_valid     = 1'b1;
        end else begin
          res_status = fvc_pkg::ST_MISS;
          pend_set   = 1'b1;
        end
      end
      fvc_pkg::OP_INVAL: begin
        if (stored.hash == cur.hash) begin
          res_status = fvc_pkg::ST_INVAL;
          clr_valid  = 1'b1;
          if (cur.hash != 64'd0 && occupied_count != '0) begin
            occ_next = occupied_count - 1'b1;
          end
        end else begin
          res_status = fvc_pkg::ST_NO_MATCH;
        end
      end
      fvc_pkg::OP_FILL: begin
        if (!pending_valid) begin
          res_status = fvc_pkg::ST_NO_PENDING;
          res_hash   = '0;
        end else begin
          res_status       = fvc_pkg::ST_FILLED;
          res_verdict      = cur.verdict;
          res_runs         = 32'd1;
          res_hash         = pending_hash;
          wr_entry.hash    = pending_hash;
          wr_entry.verdict = cur.verdict;
          wr_entry.runs    = 32'd1;
          ram_we           = exec_fire;
          set_valid        = 1'b1;
          pend_clr         = 1'b1;
          if (stored.hash == 64'd0 && pending_hash != 64'd0) begin
            occ_next = occupied_count + 1'b1;
          end else if (stored.hash != 64'd0 && pending_hash == 64'd0 &&
                       occupied_count != '0) begin
            occ_next = occupied_count - 1'b1;
          end
        end
      end
      default: begin
        res_status = fvc_pkg::ST_SHORT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= fvc_pkg::B_IDLE;
      valid          <= '0;
      pending_hash   <= '0;
      pending_valid  <= 1'b0;
      occupied_count <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (exec_fire) begin
        occupied_count <= occ_next;
        if (set_valid) begin
          valid[cur_slot] <= 1'b1;
        end else if (clr_valid) begin
          valid[cur_slot] <= 1'b0;
        end
        if (pend_set) begin
          pending_hash  <= cur.hash;
          pending_valid <= 1'b1;
        end else if (pend_clr) begin
          pending_hash  <= '0;
          pending_valid <= 1'b0;
        end
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur       <= head_op;
      cur_slot  <= rd_slot;
      cur_valid <= valid[rd_slot];
    end
    if (exec_fire) begin
      out_status  <= res_status;
      out_verdict <= res_verdict;
      out_runs    <= res_runs;
      out_occ     <= occ_next;
      out_hash    <= res_hash;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {7'd0, out_hash, out_occ, out_runs, out_verdict};

endmodule
